// ===== sv/modular_exponentiation_macros.svh =====
// assertion macros used by the modular exponentiation top level
`ifndef MODULAR_EXPONENTIATION_MACROS_SVH
`define MODULAR_EXPONENTIATION_MACROS_SVH

// same-cycle implication, checked on every clock outside reset
`define MODEXP_ASSERT_NOW(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication, checked on every clock outside reset
`define MODEXP_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== sv/modexp_pkg.sv =====
// shared types for the modular exponentiation block
`default_nettype none

package modexp_pkg;

	// top-level sequencer states, one-hot
	typedef enum logic [5:0] {
		S_IDLE    = 6'b000001,
		S_REDUCE  = 6'b000010,
		S_STEP    = 6'b000100,
		S_MUL_ACC = 6'b001000,
		S_MUL_SQ  = 6'b010000,
		S_DONE    = 6'b100000
	} state_t;

	// request to the modular multiplier
	typedef struct packed {
		logic start;
	} mul_req_t;

	// status from the modular multiplier
	typedef struct packed {
		logic busy;
		logic done;
	} mul_rsp_t;

endpackage

`default_nettype wire

// ===== sv/modexp_mul.sv =====
// bit-serial modular multiplier: msb-first double-and-add over one shared add-mod unit
`default_nettype none

module modexp_mul #(
	parameter int WORD_BITS = 64
) (
	input  wire                            clk,
	input  wire                            arst_n,
	input  modexp_pkg::mul_req_t           req,
	input  wire logic [WORD_BITS-1:0]      x,
	input  wire logic [WORD_BITS-1:0]      y,
	input  wire logic [WORD_BITS-1:0]      m,
	output modexp_pkg::mul_rsp_t           rsp,
	output logic      [WORD_BITS-1:0]      product
);

	localparam int CNT_W = $clog2(WORD_BITS);
	localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(WORD_BITS - 1);

	logic [WORD_BITS-1:0] mx_q;
	logic [WORD_BITS-1:0] my_q;
	logic [WORD_BITS-1:0] macc_q;
	logic [CNT_W-1:0]     cnt_q;
	logic                 phase_q;
	logic                 busy_q;
	logic                 done_q;

	logic [WORD_BITS-1:0] opb;
	logic [WORD_BITS-1:0] gap;
	logic [WORD_BITS-1:0] sum;
	logic                 bit_end;

	// shared add-mod unit: double in phase 0, add multiplicand in phase 1
	always_comb begin
		opb = phase_q ? mx_q : macc_q;
		gap = m - opb;
		sum = (macc_q >= gap) ? (macc_q - gap) : (macc_q + opb);
	end

	// a multiplier bit ends after its double, or after its add when set
	assign bit_end = phase_q || !my_q[WORD_BITS-1];

	// control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q  <= 1'b0;
			done_q  <= 1'b0;
			phase_q <= 1'b0;
			cnt_q   <= '0;
		end else begin
			done_q <= 1'b0;
			if (req.start) begin
				busy_q  <= 1'b1;
				phase_q <= 1'b0;
				cnt_q   <= CNT_LAST;
			end else if (busy_q) begin
				if (bit_end) begin
					phase_q <= 1'b0;
					if (cnt_q == '0) begin
						busy_q <= 1'b0;
						done_q <= 1'b1;
					end else begin
						cnt_q <= cnt_q - 1'b1;
					end
				end else begin
					phase_q <= 1'b1;
				end
			end
		end
	end

	// datapath
	always_ff @(posedge clk) begin
		if (req.start) begin
			mx_q   <= x;
			my_q   <= y;
			macc_q <= '0;
		end else if (busy_q) begin
			macc_q <= sum;
			if (bit_end) begin
				my_q <= my_q << 1;
			end
		end
	end

	assign rsp     = '{busy: busy_q, done: done_q};
	assign product = macc_q;

endmodule

`default_nettype wire

// ===== sv/modular_exponentiation.sv =====
// modular exponentiation top level: right-to-left square-and-multiply sequencer
// a multiply doubles once per multiplier bit and adds once per set bit; one reduces the base,
//   then each exponent bit a step state, a multiply when set, a square below the top set bit
// zero exponent: the sequencer goes from idle straight to done, which loads the result
//   register once the output is free and then returns to idle; one word in flight
// reset clears the sequencer and the output valid; data registers are not reset
`default_nettype none
`include "modular_exponentiation_macros.svh"

module modular_exponentiation #(
	parameter int WORD_BITS = 64
) (
	input  wire                       clk,
	input  wire                       arst_n,
	input  wire                       in_valid,
	output logic                      in_ready,
	input  wire logic [WORD_BITS-1:0] base,
	input  wire logic [WORD_BITS-1:0] exponent,
	input  wire logic [WORD_BITS-1:0] modulus,
	output logic                      out_valid,
	input  wire                       out_ready,
	output logic      [WORD_BITS-1:0] power_residue
);

	localparam logic [WORD_BITS-1:0] ONE = WORD_BITS'(1);

	modexp_pkg::state_t   state_q;
	modexp_pkg::mul_req_t mul_req;
	modexp_pkg::mul_rsp_t mul_rsp;

	logic [WORD_BITS-1:0] e_q;
	logic [WORD_BITS-1:0] m_q;
	logic [WORD_BITS-1:0] acc_q;
	logic [WORD_BITS-1:0] sq_q;
	logic [WORD_BITS-1:0] power_residue_q;
	logic                 out_valid_q;

	logic [WORD_BITS-1:0] mul_x;
	logic [WORD_BITS-1:0] mul_y;
	logic [WORD_BITS-1:0] mul_p;
	logic [WORD_BITS-1:0] one_in;
	logic                 accept;
	logic                 trivial;
	logic                 more_bits;
	logic                 load_out;

	assign in_ready  = (state_q == modexp_pkg::S_IDLE);
	assign accept    = in_valid && in_ready;
	assign trivial   = (exponent == '0) || (modulus == '0);
	assign one_in    = (modulus == ONE) ? '0 : ONE;
	assign more_bits = (e_q[WORD_BITS-1:1] != '0);
	assign load_out  = (state_q == modexp_pkg::S_DONE) && (!out_valid_q || out_ready);

	// multiplier launch: base reduction is one-times-base, then acc*sq and sq*sq
	always_comb begin
		mul_req.start = 1'b0;
		mul_x         = sq_q;
		mul_y         = sq_q;
		unique case (state_q)
			modexp_pkg::S_IDLE: begin
				mul_req.start = accept && !trivial;
				mul_x         = one_in;
				mul_y         = base;
			end
			modexp_pkg::S_STEP: begin
				mul_req.start = (e_q != '0);
				mul_x         = e_q[0] ? acc_q : sq_q;
			end
			modexp_pkg::S_MUL_ACC: begin
				mul_req.start = mul_rsp.done && more_bits;
			end
			modexp_pkg::S_REDUCE, modexp_pkg::S_MUL_SQ, modexp_pkg::S_DONE: begin
				mul_req.start = 1'b0;
			end
			default: begin
				mul_req.start = 1'b0;
			end
		endcase
	end

	modexp_mul #(
		.WORD_BITS(WORD_BITS)
	) u_mul (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (mul_req),
		.x      (mul_x),
		.y      (mul_y),
		.m      (m_q),
		.rsp    (mul_rsp),
		.product(mul_p)
	);

	// sequencer and output valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= modexp_pkg::S_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			// output valid: set on load, cleared once taken
			if (load_out) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				modexp_pkg::S_IDLE: begin
					if (accept) begin
						state_q <= trivial ? modexp_pkg::S_DONE : modexp_pkg::S_REDUCE;
					end
				end
				modexp_pkg::S_REDUCE: begin
					if (mul_rsp.done) begin
						state_q <= modexp_pkg::S_STEP;
					end
				end
				modexp_pkg::S_STEP: begin
					if (e_q == '0) begin
						state_q <= modexp_pkg::S_DONE;
					end else if (e_q[0]) begin
						state_q <= modexp_pkg::S_MUL_ACC;
					end else begin
						state_q <= modexp_pkg::S_MUL_SQ;
					end
				end
				modexp_pkg::S_MUL_ACC: begin
					if (mul_rsp.done) begin
						state_q <= more_bits ? modexp_pkg::S_MUL_SQ : modexp_pkg::S_STEP;
					end
				end
				modexp_pkg::S_MUL_SQ: begin
					if (mul_rsp.done) begin
						state_q <= modexp_pkg::S_STEP;
					end
				end
				modexp_pkg::S_DONE: begin
					if (load_out) begin
						state_q <= modexp_pkg::S_IDLE;
					end
				end
				default: begin
					state_q <= modexp_pkg::S_IDLE;
				end
			endcase
		end
	end

	// operand, running result and output word registers
	always_ff @(posedge clk) begin
		if (accept) begin
			e_q   <= exponent;
			m_q   <= modulus;
			acc_q <= (exponent == '0) ? ONE : ((modulus == '0) ? '0 : one_in);
		end
		if (mul_rsp.done) begin
			if (state_q == modexp_pkg::S_REDUCE) begin
				sq_q <= mul_p;
			end
			if (state_q == modexp_pkg::S_MUL_ACC) begin
				acc_q <= mul_p;
				if (!more_bits) begin
					e_q <= '0;
				end
			end
			if (state_q == modexp_pkg::S_MUL_SQ) begin
				sq_q <= mul_p;
				e_q  <= e_q >> 1;
			end
		end
		if (load_out) begin
			power_residue_q <= acc_q;
		end
	end

	assign out_valid     = out_valid_q;
	assign power_residue = power_residue_q;

	// checks
	`MODEXP_ASSERT_NOW(a_idle_mul_quiet, state_q == modexp_pkg::S_IDLE,
		!mul_rsp.busy && !mul_rsp.done, "multiplier active while sequencer idle")
	`MODEXP_ASSERT_NOW(a_done_in_mul_state, mul_rsp.done,
		state_q == modexp_pkg::S_REDUCE || state_q == modexp_pkg::S_MUL_ACC ||
		state_q == modexp_pkg::S_MUL_SQ, "multiplier done outside a multiply state")
	`MODEXP_ASSERT_NOW(a_step_reduced, state_q == modexp_pkg::S_STEP,
		acc_q < m_q && sq_q < m_q, "running values not reduced by modulus")
	`MODEXP_ASSERT_NEXT(a_accept_leaves_idle, accept,
		state_q != modexp_pkg::S_IDLE, "sequencer stayed idle after accepting a word")

endmodule

`default_nettype wire
